// ----- rtl/ps2_scancode_to_ascii_unit_assert.svh -----
`ifndef PS2_SCANCODE_TO_ASCII_UNIT_ASSERT_SVH
`define PS2_SCANCODE_TO_ASCII_UNIT_ASSERT_SVH

// same-cycle implication, disabled in reset
`define PS2SC_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("ps2sc: assertion failed");

// next-cycle implication, disabled in reset
`define PS2SC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("ps2sc: assertion failed");

// next-cycle implication that also covers reset itself
`define PS2SC_ASSERT_RESET(label, clk, ante, cons) \
    label: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error("ps2sc: assertion failed");

`endif

// ----- rtl/ps2sc_pkg.sv -----
package ps2sc_pkg;

    localparam int MAP_ENTRIES_DEF = 88;

    localparam logic [7:0] SC_LSHIFT_MAKE  = 8'h2A;
    localparam logic [7:0] SC_RSHIFT_MAKE  = 8'h36;
    localparam logic [7:0] SC_LSHIFT_BREAK = 8'hAA;
    localparam logic [7:0] SC_RSHIFT_BREAK = 8'hB6;
    localparam logic [7:0] SC_CTRL_MAKE    = 8'h1D;
    localparam logic [7:0] SC_CTRL_BREAK   = 8'h9D;
    localparam logic [7:0] SC_CAPS_MAKE    = 8'h3A;

    localparam logic [6:0] CH_LOWER_A = 7'h61;
    localparam logic [6:0] CH_LOWER_Z = 7'h7A;
    localparam logic [6:0] CH_UPPER_A = 7'h41;
    localparam logic [6:0] CH_UPPER_Z = 7'h5A;
    localparam logic [6:0] CH_DIGIT_0 = 7'h30;
    localparam logic [6:0] CH_DIGIT_9 = 7'h39;
    localparam logic [6:0] CH_CASE_OFFSET = 7'h20;

    typedef struct packed {
        logic shift;
        logic ctrl;
        logic caps;
    } t_mods;

    function automatic logic [6:0] key_rom(input logic [6:0] idx);
        logic [6:0] c;
        unique case (idx)
            7'h02: c = 7'h31;
            7'h03: c = 7'h32;
            7'h04: c = 7'h33;
            7'h05: c = 7'h34;
            7'h06: c = 7'h35;
            7'h07: c = 7'h36;
            7'h08: c = 7'h37;
            7'h09: c = 7'h38;
            7'h0A: c = 7'h39;
            7'h0B: c = 7'h30;
            7'h0C: c = 7'h2D;
            7'h0D: c = 7'h3D;
            7'h0E: c = 7'h08;
            7'h0F: c = 7'h09;
            7'h10: c = 7'h71;
            7'h11: c = 7'h77;
            7'h12: c = 7'h65;
            7'h13: c = 7'h72;
            7'h14: c = 7'h74;
            7'h15: c = 7'h79;
            7'h16: c = 7'h75;
            7'h17: c = 7'h69;
            7'h18: c = 7'h6F;
            7'h19: c = 7'h70;
            7'h1A: c = 7'h5B;
            7'h1B: c = 7'h5D;
            7'h1C: c = 7'h0A;
            7'h1E: c = 7'h61;
            7'h1F: c = 7'h73;
            7'h20: c = 7'h64;
            7'h21: c = 7'h66;
            7'h22: c = 7'h67;
            7'h23: c = 7'h68;
            7'h24: c = 7'h6A;
            7'h25: c = 7'h6B;
            7'h26: c = 7'h6C;
            7'h27: c = 7'h3B;
            7'h28: c = 7'h27;
            7'h29: c = 7'h60;
            7'h2B: c = 7'h5C;
            7'h2C: c = 7'h7A;
            7'h2D: c = 7'h78;
            7'h2E: c = 7'h63;
            7'h2F: c = 7'h76;
            7'h30: c = 7'h62;
            7'h31: c = 7'h6E;
            7'h32: c = 7'h6D;
            7'h33: c = 7'h2C;
            7'h34: c = 7'h2E;
            7'h35: c = 7'h2F;
            7'h37: c = 7'h2A;
            7'h39: c = 7'h20;
            default: c = 7'h00;
        endcase
        return c;
    endfunction

    function automatic logic [6:0] digit_shifted(input logic [3:0] d);
        logic [6:0] c;
        unique case (d)
            4'd0: c = 7'h29;
            4'd1: c = 7'h21;
            4'd2: c = 7'h40;
            4'd3: c = 7'h23;
            4'd4: c = 7'h24;
            4'd5: c = 7'h25;
            4'd6: c = 7'h5E;
            4'd7: c = 7'h26;
            4'd8: c = 7'h2A;
            4'd9: c = 7'h28;
            default: c = 7'h00;
        endcase
        return c;
    endfunction

endpackage

// ----- rtl/ps2sc_mods.sv -----
module ps2sc_mods import ps2sc_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_load,
    input  logic [7:0] i_scan_code,
    output t_mods      o_mods_next
);

    t_mods r_mods;
    t_mods n_mods;

    always_comb begin
        n_mods = r_mods;
        if (i_scan_code == SC_LSHIFT_MAKE || i_scan_code == SC_RSHIFT_MAKE) begin
            n_mods.shift = 1'b1;
        end else if (i_scan_code == SC_LSHIFT_BREAK || i_scan_code == SC_RSHIFT_BREAK) begin
            n_mods.shift = 1'b0;
        end
        if (i_scan_code == SC_CTRL_MAKE) begin
            n_mods.ctrl = 1'b1;
        end else if (i_scan_code == SC_CTRL_BREAK) begin
            n_mods.ctrl = 1'b0;
        end
        if (i_scan_code == SC_CAPS_MAKE) begin
            n_mods.caps = ~r_mods.caps;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mods <= '0;
        end else if (i_load) begin
            r_mods <= n_mods;
        end
    end

    assign o_mods_next = n_mods;

endmodule

// ----- rtl/ps2sc_xlate.sv -----
module ps2sc_xlate import ps2sc_pkg::*; #(
    parameter int MAP_ENTRIES = MAP_ENTRIES_DEF
) (
    input  logic [7:0] i_scan_code,
    input  t_mods      i_mods,
    output logic       o_hit,
    output logic [6:0] o_ascii_char
);

    localparam logic [7:0] LP_LIMIT = 8'(MAP_ENTRIES);

    logic [6:0] rom_char;
    logic [6:0] case_char;
    logic       is_lower;
    logic       is_digit;
    logic       is_letter;

    assign rom_char = key_rom(i_scan_code[6:0]);
    assign o_hit    = !i_scan_code[7] && (i_scan_code < LP_LIMIT) && (rom_char != 7'h00);
    assign is_lower = (rom_char >= CH_LOWER_A) && (rom_char <= CH_LOWER_Z);
    assign is_digit = (rom_char >= CH_DIGIT_0) && (rom_char <= CH_DIGIT_9);

    always_comb begin
        case_char = rom_char;
        if (i_mods.shift) begin
            if (is_lower) begin
                case_char = rom_char - CH_CASE_OFFSET;
            end else if (is_digit) begin
                case_char = digit_shifted(rom_char[3:0]);
            end
        end else if (i_mods.caps && is_lower) begin
            case_char = rom_char - CH_CASE_OFFSET;
        end
    end

    assign is_letter = ((case_char >= CH_LOWER_A) && (case_char <= CH_LOWER_Z))
                    || ((case_char >= CH_UPPER_A) && (case_char <= CH_UPPER_Z));

    assign o_ascii_char = (i_mods.ctrl && is_letter) ? {2'b00, case_char[4:0]} : case_char;

endmodule

// ----- rtl/ps2_scancode_to_ascii_unit.sv -----
// Set-1 scancode to ASCII translator. Takes one scancode byte per clock and
// offers its character on o_valid from a result register once the code is
// accepted: the code and the modifier state it leaves are held in an input
// register, then ROM lookup, shift, caps and ctrl mapping fill the result
// register. Shift, left ctrl and caps lock are updated as each code is
// accepted, so every code sees the modifiers in force at its own arrival.
// Break codes, modifier keys and unmapped codes give no result. Throughput
// is one code per cycle; o_ready drops, combinationally from i_ready, only
// while both registers are full and i_ready is low.
module ps2_scancode_to_ascii_unit import ps2sc_pkg::*; #(
    parameter int MAP_ENTRIES = MAP_ENTRIES_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_ready,
    input  logic [7:0] i_scan_code,
    output logic       o_valid,
    input  logic       i_ready,
    output logic [6:0] o_ascii_char
);

    logic       r_a_valid;
    logic [7:0] r_a_code;
    t_mods      r_a_mods;
    logic       r_b_valid;
    logic [6:0] r_b_char;
    logic       n_a_valid;
    logic       n_b_valid;

    logic       b_free;
    logic       accept;
    t_mods      mods_next;
    logic       hit;
    logic [6:0] xl_char;

    assign b_free  = !r_b_valid || i_ready;
    assign o_ready = !r_a_valid || b_free;
    assign accept  = i_valid && o_ready;

    ps2sc_mods u_mods (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_load      (accept),
        .i_scan_code (i_scan_code),
        .o_mods_next (mods_next)
    );

    ps2sc_xlate #(
        .MAP_ENTRIES (MAP_ENTRIES)
    ) u_xlate (
        .i_scan_code  (r_a_code),
        .i_mods       (r_a_mods),
        .o_hit        (hit),
        .o_ascii_char (xl_char)
    );

    assign n_a_valid = accept || (r_a_valid && !b_free);
    assign n_b_valid = b_free ? (r_a_valid && hit) : r_b_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
            r_b_valid <= 1'b0;
        end else begin
            r_a_valid <= n_a_valid;
            r_b_valid <= n_b_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_a_code <= i_scan_code;
            r_a_mods <= mods_next;
        end
        if (b_free) begin
            r_b_char <= xl_char;
        end
    end

    assign o_valid      = r_b_valid;
    assign o_ascii_char = r_b_char;

endmodule

// ----- rtl/ps2sc_checker.sv -----
`include "ps2_scancode_to_ascii_unit_assert.svh"

module ps2sc_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_valid,
    input logic       o_ready,
    input logic [7:0] i_scan_code,
    input logic       o_valid,
    input logic       i_ready,
    input logic [6:0] o_ascii_char
);

    logic in_seen;

    assign in_seen = i_valid && o_ready && (i_scan_code != 8'h00);

    `PS2SC_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_valid && !i_ready, o_valid)
    `PS2SC_ASSERT_NOW(a_char_nonzero, i_clk, i_rst_n, o_valid, o_ascii_char != 7'h00)
    `PS2SC_ASSERT_RESET(a_reset_empty, i_clk, !i_rst_n, !o_valid && o_ready)
    `PS2SC_ASSERT_NEXT(a_ready_when_drained, i_clk, i_rst_n, !o_valid && !in_seen && !i_valid,
        o_ready || !$past(o_ready))

endmodule

bind ps2_scancode_to_ascii_unit ps2sc_checker u_checker (.*);

// ----- tb/ps2_scancode_to_ascii_checker.sv -----
module ps2_scancode_to_ascii_checker import ps2sc_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_key_valid,
    input  logic       i_key_ready,
    input  logic [7:0] i_scan_code,
    input  logic       i_char_valid,
    input  logic       i_char_ready,
    input  logic [6:0] i_ascii_char,
    output int         o_mismatch_count,
    output int         o_chars_pending
);

    localparam logic [6:0] KEYMAP [58] = '{
        7'h00, 7'h00, 7'h31, 7'h32, 7'h33, 7'h34, 7'h35, 7'h36,
        7'h37, 7'h38, 7'h39, 7'h30, 7'h2D, 7'h3D, 7'h08, 7'h09,
        7'h71, 7'h77, 7'h65, 7'h72, 7'h74, 7'h79, 7'h75, 7'h69,
        7'h6F, 7'h70, 7'h5B, 7'h5D, 7'h0A, 7'h00, 7'h61, 7'h73,
        7'h64, 7'h66, 7'h67, 7'h68, 7'h6A, 7'h6B, 7'h6C, 7'h3B,
        7'h27, 7'h60, 7'h00, 7'h5C, 7'h7A, 7'h78, 7'h63, 7'h76,
        7'h62, 7'h6E, 7'h6D, 7'h2C, 7'h2E, 7'h2F, 7'h00, 7'h2A,
        7'h00, 7'h20
    };

    localparam logic [6:0] SHIFTED_DIGIT [10] = '{
        7'h29, 7'h21, 7'h40, 7'h23, 7'h24, 7'h25, 7'h5E, 7'h26, 7'h2A, 7'h28
    };

    t_mods      mods;
    logic [6:0] expected_chars [$];
    logic [6:0] key_char;
    logic [6:0] oldest;
    int         errors = 0;

    // update the modifiers from the code, then translate it under them
    function automatic logic translate_key(input logic [7:0] code, output logic [6:0] ch);
        logic [6:0] c;
        ch = '0;
        if (code == SC_LSHIFT_MAKE || code == SC_RSHIFT_MAKE) begin
            mods.shift = 1'b1;
        end else if (code == SC_LSHIFT_BREAK || code == SC_RSHIFT_BREAK) begin
            mods.shift = 1'b0;
        end
        if (code == SC_CTRL_MAKE) begin
            mods.ctrl = 1'b1;
        end else if (code == SC_CTRL_BREAK) begin
            mods.ctrl = 1'b0;
        end
        if (code == SC_CAPS_MAKE) begin
            mods.caps = ~mods.caps;
        end
        if (code[7] || int'(code) >= MAP_ENTRIES_DEF || int'(code) >= $size(KEYMAP)) begin
            return 1'b0;
        end
        c = KEYMAP[6'(code)];
        if (c == '0) begin
            return 1'b0;
        end
        if (mods.shift) begin
            if (c >= CH_LOWER_A && c <= CH_LOWER_Z) begin
                c = c - CH_CASE_OFFSET;
            end else if (c >= CH_DIGIT_0 && c <= CH_DIGIT_9) begin
                c = SHIFTED_DIGIT[4'(c - CH_DIGIT_0)];
            end
        end else if (mods.caps && c >= CH_LOWER_A && c <= CH_LOWER_Z) begin
            c = c - CH_CASE_OFFSET;
        end
        if (mods.ctrl) begin
            if (c >= CH_LOWER_A && c <= CH_LOWER_Z) begin
                c = c - CH_LOWER_A + 7'd1;
            end else if (c >= CH_UPPER_A && c <= CH_UPPER_Z) begin
                c = c - CH_UPPER_A + 7'd1;
            end
        end
        ch = c;
        return 1'b1;
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            mods = '0;
            expected_chars.delete();
        end else begin
            if (i_char_valid && i_char_ready) begin
                if (expected_chars.size() == 0) begin
                    errors++;
                    $display("%0t ascii_char: expected none, actual %h", $time, i_ascii_char);
                end else begin
                    oldest = expected_chars.pop_front();
                    if (i_ascii_char !== oldest) begin
                        errors++;
                        $display("%0t ascii_char: expected %h, actual %h",
                                 $time, oldest, i_ascii_char);
                    end
                end
            end
            if (i_key_valid && i_key_ready) begin
                if (translate_key(i_scan_code, key_char)) begin
                    expected_chars.push_back(key_char);
                end
            end
        end
        o_mismatch_count <= errors;
        o_chars_pending  <= expected_chars.size();
    end

endmodule

// ----- tb/tb_ps2_scancode_to_ascii_unit.sv -----
module tb_ps2_scancode_to_ascii_unit;
    import ps2sc_pkg::*;

    localparam int         WATCHDOG_LIMIT  = 2000;
    localparam int         HOLD_OFF_CYCLES = 300;
    localparam int         RANDOM_KEYS     = 450;
    localparam logic [7:0] BREAK_FLAG      = 8'h80;

    localparam logic [7:0] OPENING_KEYS [26] = '{
        8'h00, 8'hFF, 8'h7F, 8'h80, 8'h1E, 8'h02, 8'h0E, 8'h39, 8'h57,
        8'h58, SC_CAPS_MAKE, 8'h1E, SC_LSHIFT_MAKE, 8'h1E, 8'h0B,
        SC_CTRL_MAKE, 8'h2C, 8'h02, SC_CTRL_BREAK, SC_LSHIFT_BREAK,
        SC_RSHIFT_MAKE, 8'h10, SC_RSHIFT_BREAK, SC_CAPS_MAKE, 8'hBA, 8'h1C
    };

    localparam logic [7:0] MODIFIER_KEYS [8] = '{
        SC_LSHIFT_MAKE, SC_RSHIFT_MAKE, SC_LSHIFT_BREAK, SC_RSHIFT_BREAK,
        SC_CTRL_MAKE, SC_CTRL_BREAK, SC_CAPS_MAKE, SC_CAPS_MAKE | BREAK_FLAG
    };

    logic       i_clk;
    logic       i_rst_n;
    logic       i_valid;
    logic       o_ready;
    logic [7:0] i_scan_code;
    logic       o_valid;
    logic       i_ready;
    logic [6:0] o_ascii_char;
    logic       hold_req;
    int         mismatch_count;
    int         chars_pending;
    int         keys_sent;

    ps2_scancode_to_ascii_unit u_top (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_ready      (o_ready),
        .i_scan_code  (i_scan_code),
        .o_valid      (o_valid),
        .i_ready      (i_ready),
        .o_ascii_char (o_ascii_char)
    );

    ps2_scancode_to_ascii_checker u_checker (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_key_valid      (i_valid),
        .i_key_ready      (o_ready),
        .i_scan_code      (i_scan_code),
        .i_char_valid     (o_valid),
        .i_char_ready     (i_ready),
        .i_ascii_char     (o_ascii_char),
        .o_mismatch_count (mismatch_count),
        .o_chars_pending  (chars_pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    function automatic int gap_cycles();
        int r;
        r = int'($urandom_range(0, 19));
        if (r < 10) begin
            return 0;
        end else if (r < 18) begin
            return int'($urandom_range(1, 3));
        end
        return int'($urandom_range(10, 40));
    endfunction

    task automatic press_key(input logic [7:0] code, input int gap);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid     <= 1'b1;
        i_scan_code <= code;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        keys_sent++;
    endtask

    // drop the request and hold until every character has come back
    task automatic wait_for_chars();
        i_valid <= 1'b0;
        do @(posedge i_clk); while (chars_pending != 0);
    endtask

    initial begin
        int run;
        int gap;
        logic hold_served;
        hold_served = 1'b0;
        i_ready <= 1'b0;
        wait (i_rst_n);
        @(posedge i_clk);
        forever begin
            if (hold_req && !hold_served) begin
                hold_served = 1'b1;
                i_ready <= 1'b0;
                repeat (HOLD_OFF_CYCLES) @(posedge i_clk);
            end else begin
                run = ($urandom_range(0, 5) == 0) ? int'($urandom_range(30, 80))
                                                  : int'($urandom_range(1, 8));
                gap = gap_cycles();
                i_ready <= 1'b1;
                repeat (run) @(posedge i_clk);
                if (gap > 0) begin
                    i_ready <= 1'b0;
                    repeat (gap) @(posedge i_clk);
                end
            end
        end
    end

    initial begin
        int quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT) begin
            @(posedge i_clk);
            if (!i_rst_n || (i_valid && o_ready) || (o_valid && i_ready)) begin
                quiet = 0;
            end else begin
                quiet++;
            end
        end
        $display("status: fail");
        $finish;
    end

    initial begin
        int          target;
        int          kind;
        int          n;
        bit          burst;
        bit          pressured;
        logic [7:0]  key;
        logic [7:0]  modifier;
        keys_sent = 0;
        pressured = 1'b0;
        i_valid     <= 1'b0;
        i_scan_code <= '0;
        hold_req    <= 1'b0;
        i_rst_n     <= 1'b0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (OPENING_KEYS[k]) begin
            press_key(OPENING_KEYS[k], gap_cycles());
        end
        wait_for_chars();

        target = keys_sent + RANDOM_KEYS;
        while (keys_sent < target) begin
            if (!pressured && keys_sent >= target - RANDOM_KEYS / 2) begin
                pressured = 1'b1;
                wait_for_chars();
                hold_req <= 1'b1;
                repeat (40) press_key(8'($urandom_range(2, 8'h39)), 0);
            end
            kind  = int'($urandom_range(0, 19));
            burst = ($urandom_range(0, 7) == 0);
            if (kind < 10) begin
                key = 8'($urandom_range(2, 8'h39));
                press_key(key, burst ? 0 : gap_cycles());
                if ($urandom_range(0, 2) != 0) begin
                    press_key(key | BREAK_FLAG, burst ? 0 : gap_cycles());
                end
            end else if (kind < 15) begin
                if (kind < 13) begin
                    modifier = $urandom_range(0, 1) ? SC_LSHIFT_MAKE : SC_RSHIFT_MAKE;
                end else begin
                    modifier = SC_CTRL_MAKE;
                end
                press_key(modifier, burst ? 0 : gap_cycles());
                if (kind == 14) begin
                    press_key(SC_LSHIFT_MAKE, 0);
                end
                n = int'($urandom_range(1, 4));
                repeat (n) begin
                    key = 8'($urandom_range(2, 8'h39));
                    press_key(key, burst ? 0 : gap_cycles());
                    press_key(key | BREAK_FLAG, 0);
                end
                if (kind == 14) begin
                    press_key(SC_LSHIFT_BREAK, 0);
                end
                press_key(modifier | BREAK_FLAG, burst ? 0 : gap_cycles());
            end else if (kind < 17) begin
                press_key(MODIFIER_KEYS[3'($urandom_range(0, 7))],
                          burst ? 0 : gap_cycles());
            end else begin
                press_key(8'($urandom_range(0, 255)), burst ? 0 : gap_cycles());
            end
        end

        wait_for_chars();
        repeat (8) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule

// ----- filelist.f -----
+incdir+rtl
rtl/ps2sc_pkg.sv
rtl/ps2sc_mods.sv
rtl/ps2sc_xlate.sv
rtl/ps2_scancode_to_ascii_unit.sv
rtl/ps2sc_checker.sv
tb/ps2_scancode_to_ascii_checker.sv
tb/tb_ps2_scancode_to_ascii_unit.sv
